// ===== rtl/ddpw_pkg.sv =====
// shared types, register codes and saturation helpers for the wheel velocity controller
package ddpw_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int MacAW    = 32;
    localparam int MacBW    = 16;
    localparam int MacAccW  = 50;
    localparam int MacCntW  = $clog2(MacBW);

    localparam logic OP_CMD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int FLAG_WATCHDOG    = 0;
    localparam int FLAG_OVERCURRENT = 1;
    localparam int FLAG_STALL       = 2;

    localparam logic [15:0] RST_GAIN_P     = 16'd3277;
    localparam logic [15:0] RST_GAIN_I     = 16'd205;
    localparam logic [15:0] RST_GAIN_D     = 16'd41;
    localparam logic [15:0] RST_WD_LIMIT   = 16'd200;
    localparam logic [15:0] RST_OC_LIMIT   = 16'd7680;
    localparam logic [14:0] RST_STALL      = 15'd13;
    localparam logic [15:0] RST_INV_RADIUS = 16'd1707;
    localparam logic [15:0] RST_HALF_SEP   = 16'd1229;

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_WD_LIMIT,
        REG_OC_LIMIT,
        REG_STALL_SPEED,
        REG_INV_RADIUS,
        REG_HALF_SEP
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [15:0] wd_limit;
        logic [15:0] oc_limit;
        logic [14:0] stall_speed;
        logic [15:0] inv_radius;
        logic [15:0] half_sep;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TERM,
        ST_SPL,
        ST_SPR,
        ST_ERR,
        ST_PIDL,
        ST_PIDR,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        TERM_P,
        TERM_I,
        TERM_D
    } pid_term_t;

    function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
        logic signed [15:0] r;
        if (v > 38'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -38'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat33to32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ddpw_cfg.sv =====
// configuration register bank with reset defaults
module ddpw_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ddpw_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ddpw_pkg::CfgDataW-1:0]  cfg_wdata,
    output ddpw_pkg::cfg_t                 cfg
);

    ddpw_pkg::cfg_t cfg_reg;
    ddpw_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                ddpw_pkg::REG_GAIN_P:      cfg_next.gain_p      = cfg_wdata;
                ddpw_pkg::REG_GAIN_I:      cfg_next.gain_i      = cfg_wdata;
                ddpw_pkg::REG_GAIN_D:      cfg_next.gain_d      = cfg_wdata;
                ddpw_pkg::REG_WD_LIMIT:    cfg_next.wd_limit    = cfg_wdata;
                ddpw_pkg::REG_OC_LIMIT:    cfg_next.oc_limit    = cfg_wdata;
                ddpw_pkg::REG_STALL_SPEED: cfg_next.stall_speed = cfg_wdata[14:0];
                ddpw_pkg::REG_INV_RADIUS:  cfg_next.inv_radius  = cfg_wdata;
                ddpw_pkg::REG_HALF_SEP:    cfg_next.half_sep    = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p      <= ddpw_pkg::RST_GAIN_P;
            cfg_reg.gain_i      <= ddpw_pkg::RST_GAIN_I;
            cfg_reg.gain_d      <= ddpw_pkg::RST_GAIN_D;
            cfg_reg.wd_limit    <= ddpw_pkg::RST_WD_LIMIT;
            cfg_reg.oc_limit    <= ddpw_pkg::RST_OC_LIMIT;
            cfg_reg.stall_speed <= ddpw_pkg::RST_STALL;
            cfg_reg.inv_radius  <= ddpw_pkg::RST_INV_RADIUS;
            cfg_reg.half_sep    <= ddpw_pkg::RST_HALF_SEP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ddpw_mac.sv =====
// bit-serial multiply-accumulate unit, one multiplier bit per cycle
module ddpw_mac (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic                                  clear,
    input  logic signed [ddpw_pkg::MacAW-1:0]     a,
    input  logic        [ddpw_pkg::MacBW-1:0]     b,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [ddpw_pkg::MacAccW-1:0]   acc
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [ddpw_pkg::MacCntW-1:0]        cnt_reg, cnt_next;
    logic signed [ddpw_pkg::MacAccW-1:0] a_sh_reg, a_sh_next;
    logic [ddpw_pkg::MacBW-1:0]          b_sh_reg, b_sh_next;
    logic signed [ddpw_pkg::MacAccW-1:0] acc_reg, acc_next;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_sh_next = a_sh_reg;
        b_sh_next = b_sh_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = ddpw_pkg::MacCntW'(ddpw_pkg::MacBW - 1);
            a_sh_next = {{(ddpw_pkg::MacAccW - ddpw_pkg::MacAW){a[ddpw_pkg::MacAW-1]}}, a};
            b_sh_next = b;
            if (clear) begin
                acc_next = '0;
            end
        end else if (busy_reg) begin
            if (b_sh_reg[0]) begin
                acc_next = acc_reg + a_sh_reg;
            end
            a_sh_next = a_sh_reg <<< 1;
            b_sh_next = b_sh_reg >> 1;
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        acc_reg  <= acc_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign acc  = acc_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("multiply started while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("done raised while still iterating");

    a_run_on: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg != '0) |=> busy_reg)
        else $error("multiply stopped early");
`endif

endmodule

// ===== rtl/diff_drive_pid_watchdog.sv =====
// top level: command watchdog, wheel setpoints, two pid loops and fault latches
// A command transfer (opcode 0) stores vx and wz and clears the millisecond
// counter in the cycle it is accepted and gives no result. A tick transfer
// (opcode 1) gives one result once the result register is free: the tick
// takes nine products (yaw term, two setpoints, three pid terms per wheel)
// through one shared bit-serial multiply-accumulate unit, each over its 16
// multiplier bits, then updates the errors and loads the output register.
// The next transfer is taken once the result is in the output register,
// which holds it until the downstream side takes it; no new transfer is
// accepted while the block is still working on an earlier tick.
// Efforts are signed Q24.8, saturated to 32 bits; fault bits stay set until
// reset, except the watchdog bit, which follows the counter on every tick.
module diff_drive_pid_watchdog (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic signed [15:0]            s_cmd_vx,
    input  logic signed [15:0]            s_cmd_wz,
    input  logic signed [15:0]            s_left_speed,
    input  logic signed [15:0]            s_right_speed,
    input  logic        [15:0]            s_bus_current,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_left_effort,
    output logic signed [31:0]            m_right_effort,
    output logic        [2:0]             m_fault_flags,
    input  logic                          cfg_we,
    input  logic [ddpw_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ddpw_pkg::CfgDataW-1:0] cfg_wdata
);

    ddpw_pkg::cfg_t cfg;

    ddpw_pkg::state_t    state_reg, state_next;
    ddpw_pkg::pid_term_t idx_reg, idx_next;
    logic                issued_reg, issued_next;

    logic signed [15:0] held_vx_reg, held_vx_next;
    logic signed [15:0] held_wz_reg, held_wz_next;
    logic [15:0]        ms_reg, ms_next;
    logic [2:0]         fault_reg, fault_next;
    logic signed [31:0] integ_reg [0:1];
    logic signed [31:0] integ_next [0:1];
    logic signed [16:0] prev_reg [0:1];
    logic signed [16:0] prev_next [0:1];

    logic signed [15:0] vx_reg, vx_next;
    logic signed [15:0] wz_reg, wz_next;
    logic signed [15:0] spd_reg [0:1];
    logic signed [15:0] spd_next [0:1];
    logic [15:0]        cur_reg, cur_next;
    logic signed [20:0] term_reg, term_next;
    logic signed [15:0] sp_reg [0:1];
    logic signed [15:0] sp_next [0:1];
    logic signed [16:0] err_reg [0:1];
    logic signed [16:0] err_next [0:1];
    logic signed [17:0] deriv_reg [0:1];
    logic signed [17:0] deriv_next [0:1];
    logic signed [31:0] eff_reg [0:1];
    logic signed [31:0] eff_next [0:1];

    logic               m_valid_reg, m_valid_next;
    logic signed [31:0] m_left_reg, m_left_next;
    logic signed [31:0] m_right_reg, m_right_next;
    logic [2:0]         m_flags_reg, m_flags_next;

    logic                                 mac_start;
    logic                                 mac_clear;
    logic signed [ddpw_pkg::MacAW-1:0]    mac_a;
    logic        [ddpw_pkg::MacBW-1:0]    mac_b;
    logic                                 mac_busy;
    logic                                 mac_done;
    logic signed [ddpw_pkg::MacAccW-1:0]  mac_acc;

    logic [15:0]        ms_inc;
    logic               wd_trip;
    logic signed [21:0] diff_l;
    logic signed [21:0] diff_r;
    logic               side;
    logic signed [15:0] sp_g [0:1];
    logic signed [16:0] err_w [0:1];
    logic signed [32:0] integ_sum [0:1];
    logic signed [17:0] deriv_w [0:1];
    logic signed [15:0] stall_lim;
    logic               stall_hit;
    logic               oc_hit;

    ddpw_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ddpw_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .clear   (mac_clear),
        .a       (mac_a),
        .b       (mac_b),
        .busy    (mac_busy),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    // per-tick datapath
    always_comb begin
        ms_inc    = (ms_reg == 16'hffff) ? ms_reg : ms_reg + 16'd1;
        wd_trip   = ms_inc > cfg.wd_limit;
        diff_l    = {{6{vx_reg[15]}}, vx_reg} - {term_reg[20], term_reg};
        diff_r    = {{6{vx_reg[15]}}, vx_reg} + {term_reg[20], term_reg};
        side      = (state_reg == ddpw_pkg::ST_PIDR);
        stall_lim = $signed({1'b0, cfg.stall_speed});
        for (int i = 0; i < 2; i++) begin
            sp_g[i]      = (fault_reg != 3'd0) ? 16'sd0 : sp_reg[i];
            err_w[i]     = {sp_g[i][15], sp_g[i]} - {spd_reg[i][15], spd_reg[i]};
            integ_sum[i] = {integ_reg[i][31], integ_reg[i]}
                         + {{16{err_w[i][16]}}, err_w[i]};
            deriv_w[i]   = {err_w[i][16], err_w[i]} - {prev_reg[i][16], prev_reg[i]};
        end
        stall_hit = ((sp_g[0] != 16'sd0) || (sp_g[1] != 16'sd0))
                  && (spd_reg[0] < stall_lim) && (spd_reg[1] < stall_lim);
        oc_hit    = cur_reg > cfg.oc_limit;
    end

    // multiplier operand selection
    always_comb begin
        mac_a     = '0;
        mac_b     = '0;
        mac_clear = 1'b1;
        case (state_reg)
            ddpw_pkg::ST_TERM: begin
                mac_a = {{16{wz_reg[15]}}, wz_reg};
                mac_b = cfg.half_sep;
            end
            ddpw_pkg::ST_SPL: begin
                mac_a = {{10{diff_l[21]}}, diff_l};
                mac_b = cfg.inv_radius;
            end
            ddpw_pkg::ST_SPR: begin
                mac_a = {{10{diff_r[21]}}, diff_r};
                mac_b = cfg.inv_radius;
            end
            ddpw_pkg::ST_PIDL, ddpw_pkg::ST_PIDR: begin
                case (idx_reg)
                    ddpw_pkg::TERM_I: begin
                        mac_a     = integ_reg[side];
                        mac_b     = cfg.gain_i;
                        mac_clear = 1'b0;
                    end
                    ddpw_pkg::TERM_D: begin
                        mac_a     = {{14{deriv_reg[side][17]}}, deriv_reg[side]};
                        mac_b     = cfg.gain_d;
                        mac_clear = 1'b0;
                    end
                    default: begin
                        mac_a = {{15{err_reg[side][16]}}, err_reg[side]};
                        mac_b = cfg.gain_p;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        issued_next  = issued_reg;
        held_vx_next = held_vx_reg;
        held_wz_next = held_wz_reg;
        ms_next      = ms_reg;
        fault_next   = fault_reg;
        integ_next   = integ_reg;
        prev_next    = prev_reg;
        vx_next      = vx_reg;
        wz_next      = wz_reg;
        spd_next     = spd_reg;
        cur_next     = cur_reg;
        term_next    = term_reg;
        sp_next      = sp_reg;
        err_next     = err_reg;
        deriv_next   = deriv_reg;
        eff_next     = eff_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_left_next  = m_left_reg;
        m_right_next = m_right_reg;
        m_flags_next = m_flags_reg;
        mac_start    = 1'b0;
        s_ready      = (state_reg == ddpw_pkg::ST_IDLE);

        case (state_reg)
            ddpw_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == ddpw_pkg::OP_CMD) begin
                        held_vx_next = s_cmd_vx;
                        held_wz_next = s_cmd_wz;
                        ms_next      = '0;
                    end else begin
                        ms_next = ms_inc;
                        fault_next[ddpw_pkg::FLAG_WATCHDOG] = wd_trip;
                        vx_next     = wd_trip ? 16'sd0 : held_vx_reg;
                        wz_next     = wd_trip ? 16'sd0 : held_wz_reg;
                        spd_next[0] = s_left_speed;
                        spd_next[1] = s_right_speed;
                        cur_next    = s_bus_current;
                        state_next  = ddpw_pkg::ST_TERM;
                    end
                end
            end
            ddpw_pkg::ST_TERM: begin
                if (!issued_reg) begin
                    mac_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mac_done) begin
                    issued_next = 1'b0;
                    term_next   = mac_acc[32:12];
                    state_next  = ddpw_pkg::ST_SPL;
                end
            end
            ddpw_pkg::ST_SPL: begin
                if (!issued_reg) begin
                    mac_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mac_done) begin
                    issued_next = 1'b0;
                    sp_next[0]  = ddpw_pkg::sat16(mac_acc[49:12]);
                    state_next  = ddpw_pkg::ST_SPR;
                end
            end
            ddpw_pkg::ST_SPR: begin
                if (!issued_reg) begin
                    mac_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mac_done) begin
                    issued_next = 1'b0;
                    sp_next[1]  = ddpw_pkg::sat16(mac_acc[49:12]);
                    state_next  = ddpw_pkg::ST_ERR;
                end
            end
            ddpw_pkg::ST_ERR: begin
                for (int i = 0; i < 2; i++) begin
                    err_next[i]   = err_w[i];
                    integ_next[i] = ddpw_pkg::sat33to32(integ_sum[i]);
                    deriv_next[i] = deriv_w[i];
                    prev_next[i]  = err_w[i];
                end
                if (oc_hit) begin
                    fault_next[ddpw_pkg::FLAG_OVERCURRENT] = 1'b1;
                end
                if (stall_hit) begin
                    fault_next[ddpw_pkg::FLAG_STALL] = 1'b1;
                end
                idx_next   = ddpw_pkg::TERM_P;
                state_next = ddpw_pkg::ST_PIDL;
            end
            ddpw_pkg::ST_PIDL, ddpw_pkg::ST_PIDR: begin
                if (!issued_reg) begin
                    mac_start   = 1'b1;
                    issued_next = 1'b1;
                end else if (mac_done) begin
                    issued_next = 1'b0;
                    case (idx_reg)
                        ddpw_pkg::TERM_P: idx_next = ddpw_pkg::TERM_I;
                        ddpw_pkg::TERM_I: idx_next = ddpw_pkg::TERM_D;
                        default: begin
                            idx_next       = ddpw_pkg::TERM_P;
                            eff_next[side] = ddpw_pkg::sat32(mac_acc[49:12]);
                            state_next     = side ? ddpw_pkg::ST_OUT : ddpw_pkg::ST_PIDR;
                        end
                    endcase
                end
            end
            ddpw_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_left_next  = eff_reg[0];
                    m_right_next = eff_reg[1];
                    m_flags_next = fault_reg;
                    state_next   = ddpw_pkg::ST_IDLE;
                end
            end
            default: state_next = ddpw_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ddpw_pkg::ST_IDLE;
            idx_reg     <= ddpw_pkg::TERM_P;
            issued_reg  <= 1'b0;
            held_vx_reg <= '0;
            held_wz_reg <= '0;
            ms_reg      <= '0;
            fault_reg   <= '0;
            integ_reg   <= '{default: '0};
            prev_reg    <= '{default: '0};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            issued_reg  <= issued_next;
            held_vx_reg <= held_vx_next;
            held_wz_reg <= held_wz_next;
            ms_reg      <= ms_next;
            fault_reg   <= fault_next;
            integ_reg   <= integ_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        vx_reg      <= vx_next;
        wz_reg      <= wz_next;
        spd_reg     <= spd_next;
        cur_reg     <= cur_next;
        term_reg    <= term_next;
        sp_reg      <= sp_next;
        err_reg     <= err_next;
        deriv_reg   <= deriv_next;
        eff_reg     <= eff_next;
        m_left_reg  <= m_left_next;
        m_right_reg <= m_right_next;
        m_flags_reg <= m_flags_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_left_effort  = m_left_reg;
    assign m_right_effort = m_right_reg;
    assign m_fault_flags  = m_flags_reg;

`ifndef NO_ASSERTIONS
    a_cmd_clears_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == ddpw_pkg::OP_CMD) |=> (ms_reg == 16'd0))
        else $error("command transfer did not clear the millisecond counter");

    a_latches_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (fault_reg[2:1] != 2'b00) |=>
            ((fault_reg[2:1] & $past(fault_reg[2:1])) == $past(fault_reg[2:1])))
        else $error("over-current or stall latch cleared");

    a_idle_mac_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddpw_pkg::ST_IDLE) |-> (!mac_busy && !mac_start))
        else $error("multiplier active while idle");
`endif

endmodule

// ===== test/tb_diff_drive_pid_watchdog.sv =====
// testbench for the wheel velocity controller: directed table and random traffic, checked against a predictor
`timescale 1ns / 1ps

module tb_diff_drive_pid_watchdog;

    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 170;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_GAP       = 19;
    localparam int MAX_REPORTS   = 50;
    localparam int N_ROWS        = 21;
    localparam int LATCH_ROW     = 16;

    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint S16_MIN = -64'sd32768;
    localparam longint S16_MAX = 64'sd32767;

    localparam ddpw_pkg::cfg_t RESET_CFG = '{
        gain_p: ddpw_pkg::RST_GAIN_P, gain_i: ddpw_pkg::RST_GAIN_I,
        gain_d: ddpw_pkg::RST_GAIN_D, wd_limit: ddpw_pkg::RST_WD_LIMIT,
        oc_limit: ddpw_pkg::RST_OC_LIMIT, stall_speed: ddpw_pkg::RST_STALL,
        inv_radius: ddpw_pkg::RST_INV_RADIUS, half_sep: ddpw_pkg::RST_HALF_SEP
    };

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] vx;
        logic signed [15:0] wz;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic        [15:0] bus_current;
    } ctrl_item_t;

    typedef struct packed {
        logic signed [31:0] left;
        logic signed [31:0] right;
        logic        [2:0]  flags;
    } wheel_out_t;

    typedef struct packed {
        ctrl_item_t it;
        logic       known;
        wheel_out_t want;
    } dir_row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = ddpw_pkg::OP_CMD;
    logic signed [15:0] s_cmd_vx = '0;
    logic signed [15:0] s_cmd_wz = '0;
    logic signed [15:0] s_left_speed = '0;
    logic signed [15:0] s_right_speed = '0;
    logic        [15:0] s_bus_current = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_left_effort;
    logic signed [31:0] m_right_effort;
    logic        [2:0]  m_fault_flags;
    logic               cfg_we = 1'b0;
    ddpw_pkg::cfg_idx_t cfg_index = ddpw_pkg::REG_GAIN_P;
    logic [ddpw_pkg::CfgDataW-1:0] cfg_wdata = '0;

    // predictor state
    ddpw_pkg::cfg_t     ctrl_cfg = RESET_CFG;
    logic signed [15:0] cmd_vx_q = '0;
    logic signed [15:0] cmd_wz_q = '0;
    logic        [15:0] ms_count = '0;
    logic        [2:0]  fault_q = '0;
    int                 integ_q [2] = '{0, 0};
    int                 last_err_q [2] = '{0, 0};

    wheel_out_t pending_efforts [$];
    int         errors = 0;
    int         quiet_cycles = 0;
    bit         hold_req = 1'b0;
    bit         send_calm = 1'b0;
    bit         recv_calm = 1'b0;

    // latch rows go last, nothing clears those faults but reset
    dir_row_t dir_rows [N_ROWS] = '{
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000},
          1'b1, '{32'sd0, 32'sd0, 3'b000}},
        '{'{ddpw_pkg::OP_CMD,  16'sh7fff, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 16'hffff},
          1'b0, '0},
        '{'{ddpw_pkg::OP_CMD,  16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh8000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh0064, 16'sh7fff, 16'h1e00},
          1'b0, '0},
        '{'{ddpw_pkg::OP_CMD,  16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 16'h8000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh000d, 16'sh8000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh5555, 16'shaaaa, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_CMD,  16'shaaaa, 16'sh5555, 16'shffff, 16'shffff, 16'hffff},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh4000, 16'shc000, 16'h1234},
          1'b0, '0},
        '{'{ddpw_pkg::OP_CMD,  16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh8000, 16'hffff},
          1'b0, '0},
        '{'{ddpw_pkg::OP_CMD,  16'sh1000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 16'hffff},
          1'b0, '0},
        '{'{ddpw_pkg::OP_CMD,  16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0},
        '{'{ddpw_pkg::OP_TICK, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'h0000},
          1'b0, '0}
    };

    diff_drive_pid_watchdog i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_cmd_vx       (s_cmd_vx),
        .s_cmd_wz       (s_cmd_wz),
        .s_left_speed   (s_left_speed),
        .s_right_speed  (s_right_speed),
        .s_bus_current  (s_bus_current),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_effort  (m_left_effort),
        .m_right_effort (m_right_effort),
        .m_fault_flags  (m_fault_flags),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int wheel_pid(int side, longint setpt, longint meas);
        longint err;
        longint deriv;
        longint acc;
        err = setpt - meas;
        integ_q[side] = int'(clamp(longint'(integ_q[side]) + err, I32_MIN, I32_MAX));
        deriv = err - longint'(last_err_q[side]);
        last_err_q[side] = int'(err);
        acc = longint'(ctrl_cfg.gain_p) * err
            + longint'(ctrl_cfg.gain_i) * longint'(integ_q[side])
            + longint'(ctrl_cfg.gain_d) * deriv;
        return int'(clamp(acc >>> 12, I32_MIN, I32_MAX));
    endfunction

    // returns 1 when the item gives a result
    function automatic bit step_ctrl(input ctrl_item_t it, output wheel_out_t r);
        longint vx;
        longint wz;
        longint term;
        longint sp_l;
        longint sp_r;
        longint lsp;
        longint rsp;
        r = '0;
        if (it.opcode == ddpw_pkg::OP_CMD) begin
            cmd_vx_q = it.vx;
            cmd_wz_q = it.wz;
            ms_count = '0;
            return 1'b0;
        end
        lsp = longint'($signed(it.left_speed));
        rsp = longint'($signed(it.right_speed));
        if (ms_count != 16'hffff) begin
            ms_count = ms_count + 16'd1;
        end
        if (ms_count > ctrl_cfg.wd_limit) begin
            vx = 0;
            wz = 0;
            fault_q[ddpw_pkg::FLAG_WATCHDOG] = 1'b1;
        end else begin
            vx = longint'($signed(cmd_vx_q));
            wz = longint'($signed(cmd_wz_q));
            fault_q[ddpw_pkg::FLAG_WATCHDOG] = 1'b0;
        end
        term = (wz * longint'(ctrl_cfg.half_sep)) >>> 12;
        sp_l = clamp(((vx - term) * longint'(ctrl_cfg.inv_radius)) >>> 12, S16_MIN, S16_MAX);
        sp_r = clamp(((vx + term) * longint'(ctrl_cfg.inv_radius)) >>> 12, S16_MIN, S16_MAX);
        if (fault_q != 3'b000) begin
            sp_l = 0;
            sp_r = 0;
        end
        r.left = wheel_pid(0, sp_l, lsp);
        r.right = wheel_pid(1, sp_r, rsp);
        if (it.bus_current > ctrl_cfg.oc_limit) begin
            fault_q[ddpw_pkg::FLAG_OVERCURRENT] = 1'b1;
        end
        if ((sp_l != 0 || sp_r != 0) && lsp < longint'(ctrl_cfg.stall_speed)
                && rsp < longint'(ctrl_cfg.stall_speed)) begin
            fault_q[ddpw_pkg::FLAG_STALL] = 1'b1;
        end
        r.flags = fault_q;
        return 1'b1;
    endfunction

    function automatic logic signed [15:0] pick_s16();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // clean items keep the over-current and stall latches clear
    function automatic ctrl_item_t random_item(bit clean);
        ctrl_item_t it;
        it.opcode = ($urandom_range(7) == 0) ? ddpw_pkg::OP_CMD : ddpw_pkg::OP_TICK;
        it.vx = pick_s16();
        it.wz = pick_s16();
        it.left_speed = pick_s16();
        it.right_speed = pick_s16();
        it.bus_current = 16'($urandom);
        if (clean) begin
            it.bus_current = 16'($urandom_range(ctrl_cfg.oc_limit));
            it.left_speed = 16'($urandom_range(32767, ctrl_cfg.stall_speed));
        end
        return it;
    endfunction

    function automatic ddpw_pkg::cfg_t random_cfg();
        ddpw_pkg::cfg_t c;
        c.gain_p = 16'($urandom);
        c.gain_i = 16'($urandom);
        c.gain_d = 16'($urandom);
        c.wd_limit = $urandom_range(1) ? 16'($urandom_range(40)) : 16'($urandom);
        c.oc_limit = 16'($urandom);
        c.stall_speed = 15'($urandom);
        c.inv_radius = 16'($urandom);
        c.half_sep = 16'($urandom);
        return c;
    endfunction

    task automatic note_mismatch(string what);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t mismatch: %s", $time, what);
        end
    endtask

    task automatic put_reg(ddpw_pkg::cfg_idx_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    task automatic apply_config(ddpw_pkg::cfg_t c);
        put_reg(ddpw_pkg::REG_GAIN_P, c.gain_p);
        put_reg(ddpw_pkg::REG_GAIN_I, c.gain_i);
        put_reg(ddpw_pkg::REG_GAIN_D, c.gain_d);
        put_reg(ddpw_pkg::REG_WD_LIMIT, c.wd_limit);
        put_reg(ddpw_pkg::REG_OC_LIMIT, c.oc_limit);
        // top bit of the stall register is unused
        put_reg(ddpw_pkg::REG_STALL_SPEED, {1'($urandom), c.stall_speed});
        put_reg(ddpw_pkg::REG_INV_RADIUS, c.inv_radius);
        put_reg(ddpw_pkg::REG_HALF_SEP, c.half_sep);
        cfg_we <= 1'b0;
        ctrl_cfg = c;
    endtask

    task automatic send_item(ctrl_item_t it, logic known, wheel_out_t want);
        int gap;
        wheel_out_t got;
        if ($urandom_range(31) == 0) begin
            send_calm = !send_calm;
        end
        gap = send_calm ? 0 : $urandom_range(MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= it.opcode;
        s_cmd_vx <= it.vx;
        s_cmd_wz <= it.wz;
        s_left_speed <= it.left_speed;
        s_right_speed <= it.right_speed;
        s_bus_current <= it.bus_current;
        do @(posedge aclk); while (!s_ready);
        if (step_ctrl(it, got)) begin
            pending_efforts.push_back(known ? want : got);
        end
    endtask

    task automatic run_random(int n, bit clean, int hold_at);
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) begin
                hold_req = 1'b1;
            end
            send_item(random_item(clean), 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_efforts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : result_side
        wheel_out_t want;
        int stall;
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(31) == 0) begin
                    recv_calm = !recv_calm;
                end
                stall = recv_calm ? 0 : $urandom_range(MAX_GAP);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_efforts.size() == 0) begin
                note_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_efforts.pop_front();
                if (m_left_effort !== want.left) begin
                    note_mismatch($sformatf("left effort %0d, expected %0d",
                        m_left_effort, want.left));
                end
                if (m_right_effort !== want.right) begin
                    note_mismatch($sformatf("right effort %0d, expected %0d",
                        m_right_effort, want.right));
                end
                if (m_fault_flags !== want.flags) begin
                    note_mismatch($sformatf("fault flags %b, expected %b",
                        m_fault_flags, want.flags));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        ddpw_pkg::cfg_t cfg;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        cfg = RESET_CFG;
        cfg.wd_limit = 16'd3;
        cfg.oc_limit = 16'hffff;
        apply_config(cfg);
        for (int r = 0; r < LATCH_ROW; r++) begin
            send_item(dir_rows[r].it, dir_rows[r].known, dir_rows[r].want);
        end
        drain_results();

        apply_config(RESET_CFG);
        run_random(300, 1'b1, 60);
        drain_results();

        apply_config('{gain_p: '1, gain_i: '1, gain_d: '1, wd_limit: '1, oc_limit: '1,
                       stall_speed: '0, inv_radius: '1, half_sep: '1});
        run_random(250, 1'b1, -1);
        drain_results();

        apply_config('{gain_p: '0, gain_i: '0, gain_d: '0, wd_limit: '0, oc_limit: '1,
                       stall_speed: '1, inv_radius: '0, half_sep: '0});
        run_random(100, 1'b1, -1);
        drain_results();

        for (int k = 0; k < 5; k++) begin
            cfg = random_cfg();
            cfg.wd_limit = 16'($urandom_range(24));
            apply_config(cfg);
            run_random(60, 1'b1, (k == 2) ? 20 : -1);
            drain_results();
        end

        apply_config(RESET_CFG);
        for (int r = LATCH_ROW; r < N_ROWS; r++) begin
            send_item(dir_rows[r].it, dir_rows[r].known, dir_rows[r].want);
        end
        drain_results();

        for (int k = 0; k < 7; k++) begin
            apply_config(random_cfg());
            run_random(55, 1'b0, -1);
            drain_results();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ddpw_pkg.sv
rtl/ddpw_cfg.sv
rtl/ddpw_mac.sv
rtl/diff_drive_pid_watchdog.sv
test/tb_diff_drive_pid_watchdog.sv
